>>> rtl/gsl_pkg.sv
// ============================================================================
// gsl_pkg - shared types and constants for the sorted list cursor
// Widths, action codes, item words and the memory request bundle.
// ============================================================================
package gsl_pkg;

    localparam int LIST_DEPTH = 65536;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_REWIND = 3'd1;
    localparam logic [2:0] ACT_PEEK   = 3'd2;
    localparam logic [2:0] ACT_NEXT   = 3'd3;
    localparam logic [2:0] ACT_FIND   = 3'd4;

    typedef struct packed {
        logic [2:0]        action;
        logic [DATA_W-1:0] target;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic              exhausted;
    } t_out_word;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

endpackage

>>> rtl/gsl_ram.sv
// ============================================================================
// gsl_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module gsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/gsl_engine.sv
// ============================================================================
// gsl_engine - cursor state and galloping search sequencer
// Keeps cursor, remaining and loaded counts; probes the entry store
// one read per compare and hands finished results to the output stage.
// ============================================================================
module gsl_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gsl_pkg::t_in_word          i_in_word,
    input  logic [gsl_pkg::DATA_W-1:0] i_end_marker,
    output gsl_pkg::t_mem_req          o_mem_req,
    input  logic [gsl_pkg::DATA_W-1:0] i_rd_data,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output gsl_pkg::t_out_word         o_res_word
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ISSUE,
        S_EMIT_RD,
        S_UP_ISSUE,
        S_UP_CMP,
        S_DN_ISSUE,
        S_DN_CMP,
        S_FIN_CMP,
        S_OUT
    } t_state;

    t_state                      r_state,  n_state;
    logic [gsl_pkg::CNT_W-1:0]   r_cur,    n_cur;
    logic [gsl_pkg::CNT_W-1:0]   r_rem,    n_rem;
    logic [gsl_pkg::CNT_W-1:0]   r_loaded, n_loaded;
    logic [gsl_pkg::CNT_W-1:0]   r_step,   n_step;
    logic [gsl_pkg::DATA_W-1:0]  r_tgt,    n_tgt;
    logic                        r_is_next, n_is_next;
    gsl_pkg::t_out_word          r_res,    n_res;

    logic [gsl_pkg::CNT_W-1:0]   w_probe;
    logic                        w_accept;
    gsl_pkg::t_out_word          w_end_res;

    assign w_probe   = r_cur + r_step;
    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_end_res = '{position: i_end_marker, exhausted: 1'b1};

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_rem     = r_rem;
        n_loaded  = r_loaded;
        n_step    = r_step;
        n_tgt     = r_tgt;
        n_is_next = r_is_next;
        n_res     = r_res;

        o_mem_req.wr_en   = 1'b0;
        o_mem_req.wr_addr = r_loaded[gsl_pkg::ADDR_W-1:0];
        o_mem_req.wr_data = i_in_word.target;
        o_mem_req.rd_addr = w_probe[gsl_pkg::ADDR_W-1:0];
        if (r_state == S_IDLE || r_state == S_RD_ISSUE) begin
            o_mem_req.rd_addr = r_cur[gsl_pkg::ADDR_W-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.action)
                        gsl_pkg::ACT_APPEND: begin
                            if (r_loaded < gsl_pkg::DEPTH_CNT) begin
                                o_mem_req.wr_en = 1'b1;
                                n_loaded        = r_loaded + gsl_pkg::ONE_CNT;
                            end
                        end
                        gsl_pkg::ACT_REWIND: begin
                            n_cur = '0;
                            n_rem = r_loaded;
                        end
                        gsl_pkg::ACT_PEEK, gsl_pkg::ACT_NEXT: begin
                            n_is_next = (i_in_word.action == gsl_pkg::ACT_NEXT);
                            if (r_rem == '0) begin
                                n_res   = w_end_res;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_EMIT_RD;
                            end
                        end
                        gsl_pkg::ACT_FIND: begin
                            n_tgt     = i_in_word.target;
                            n_is_next = 1'b0;
                            if (r_rem == '0) begin
                                n_res   = w_end_res;
                                n_state = S_OUT;
                            end else begin
                                n_step  = gsl_pkg::ONE_CNT;
                                n_state = S_UP_ISSUE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_ISSUE: begin
                n_state = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_res = '{position: i_rd_data, exhausted: 1'b0};
                if (r_is_next) begin
                    n_cur = r_cur + gsl_pkg::ONE_CNT;
                    n_rem = r_rem - gsl_pkg::ONE_CNT;
                end
                n_state = S_OUT;
            end
            S_UP_ISSUE: begin
                n_state = (r_step < r_rem) ? S_UP_CMP : S_DN_ISSUE;
            end
            S_UP_CMP: begin
                if (i_rd_data <= r_tgt) begin
                    n_cur   = w_probe;
                    n_rem   = r_rem - r_step;
                    n_step  = r_step << 1;
                    n_state = S_UP_ISSUE;
                end else begin
                    n_state = S_DN_ISSUE;
                end
            end
            S_DN_ISSUE: begin
                // step zero probes the cursor entry itself
                if (r_step == '0) begin
                    n_state = S_FIN_CMP;
                end else if (r_step < r_rem) begin
                    n_state = S_DN_CMP;
                end else begin
                    n_step = r_step >> 1;
                end
            end
            S_DN_CMP: begin
                if (i_rd_data <= r_tgt) begin
                    n_cur = w_probe;
                    n_rem = r_rem - r_step;
                end
                n_step  = r_step >> 1;
                n_state = S_DN_ISSUE;
            end
            S_FIN_CMP: begin
                if (i_rd_data < r_tgt) begin
                    n_cur = r_cur + gsl_pkg::ONE_CNT;
                    n_rem = r_rem - gsl_pkg::ONE_CNT;
                    if (r_rem == gsl_pkg::ONE_CNT) begin
                        n_res   = w_end_res;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD_ISSUE;
                    end
                end else begin
                    n_res   = '{position: i_rd_data, exhausted: 1'b0};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_rem    <= '0;
            r_loaded <= '0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_rem    <= n_rem;
            r_loaded <= n_loaded;
        end
        r_step    <= n_step;
        r_tgt     <= n_tgt;
        r_is_next <= n_is_next;
        r_res     <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res_word  = r_res;

    a_span_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cur} + {1'b0, r_rem}) <= {1'b0, r_loaded})
        else $error("cursor span exceeds loaded entries");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= gsl_pkg::DEPTH_CNT)
        else $error("loaded count beyond depth");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP || r_state == S_DN_CMP) |-> (r_step < r_rem))
        else $error("probe past remaining entries");

    a_exhausted_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res_word.exhausted) |-> (o_res_word.position == i_end_marker))
        else $error("exhausted result without end marker");

endmodule

>>> rtl/gsl_outreg.sv
// ============================================================================
// gsl_outreg - result output register
// Holds one finished word so the engine can go back to work while the
// downstream side stalls.
// ============================================================================
module gsl_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_word_valid,
    output logic               o_word_ready,
    input  gsl_pkg::t_out_word i_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gsl_pkg::t_out_word o_out_word
);

    logic               r_valid;
    gsl_pkg::t_out_word r_word;
    logic               w_load;

    assign o_word_ready = !r_valid || !i_out_stall;
    assign w_load       = i_word_valid && o_word_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_word_ready) begin
            r_valid <= i_word_valid;
        end
        if (w_load) begin
            r_word <= i_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

>>> rtl/galloping_sorted_list_cursor.sv
// ============================================================================
// galloping_sorted_list_cursor - cursor over an ascending list in memory
// Append, rewind, peek, next and galloping find over a 64K-entry store.
// ============================================================================
// Append and rewind give no result. Peek and next read the entry under
// the cursor, capture the read data and hand it to the output register.
// Find probes the single read port of the entry store with an address
// state and then a compare state per probe, galloping up by doubling steps
// and then narrowing down; a target close to the cursor needs fewer probes
// than a far one. Peek, next or find with nothing remaining answers the end
// marker. A waiting result sits in the output register, so the next word is
// taken while it is stalled.
module galloping_sorted_list_cursor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gsl_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gsl_pkg::t_out_word         o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gsl_pkg::DATA_W-1:0] i_cfg_data
);

    logic [gsl_pkg::DATA_W-1:0] r_end_marker;
    gsl_pkg::t_mem_req          w_mem_req;
    logic [gsl_pkg::DATA_W-1:0] w_rd_data;
    logic                       w_res_valid;
    logic                       w_res_ready;
    gsl_pkg::t_out_word         w_res_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker <= '1;
        end else if (i_cfg_valid) begin
            r_end_marker <= i_cfg_data;
        end
    end

    gsl_ram #(
        .WIDTH (gsl_pkg::DATA_W),
        .DEPTH (gsl_pkg::LIST_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_req.wr_en),
        .i_wr_addr (w_mem_req.wr_addr),
        .i_wr_data (w_mem_req.wr_data),
        .i_rd_addr (w_mem_req.rd_addr),
        .o_rd_data (w_rd_data)
    );

    gsl_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_end_marker (r_end_marker),
        .o_mem_req    (w_mem_req),
        .i_rd_data    (w_rd_data),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res_word   (w_res_word)
    );

    gsl_outreg u_outreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (w_res_valid),
        .o_word_ready (w_res_ready),
        .i_word       (w_res_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

endmodule

>>> verif/testbench.sv
// ============================================================================
// testbench - self-checking bench for galloping_sorted_list_cursor
// Drives append, rewind, peek, next and find words with random idling on both
// sides, predicts every reply word from an internal copy of the list and the
// cursor, and compares replies in order. Ends with long finds and no idling.
// ============================================================================
module testbench;
    import gsl_pkg::*;

    localparam logic [2:0] ACT_LAST = 3'd7;

    class cursor_checker;
        bit [DATA_W-1:0] entries [LIST_DEPTH];
        int unsigned     cursor;
        int unsigned     remaining;
        int unsigned     loaded;
        bit [DATA_W-1:0] end_marker;
        t_out_word       pending [$];
        int              errors;

        function new();
            cursor     = 0;
            remaining  = 0;
            loaded     = 0;
            end_marker = '1;
            errors     = 0;
        endfunction

        function bit can_step(int unsigned step, bit [DATA_W-1:0] tgt);
            return step < remaining && entries[cursor + step] <= tgt;
        endfunction

        function void expect_reply(bit have);
            t_out_word w;
            w.position  = have ? entries[cursor] : end_marker;
            w.exhausted = !have;
            pending = {pending, w};
        endfunction

        function void note_command(t_in_word w);
            int unsigned step;
            step = 1;
            case (w.action)
                ACT_APPEND: begin
                    if (loaded < LIST_DEPTH) begin
                        entries[loaded] = w.target;
                        loaded++;
                    end
                end
                ACT_REWIND: begin
                    cursor    = 0;
                    remaining = loaded;
                end
                ACT_PEEK: begin
                    expect_reply(remaining > 0);
                end
                ACT_NEXT: begin
                    expect_reply(remaining > 0);
                    if (remaining > 0) begin
                        cursor++;
                        remaining--;
                    end
                end
                ACT_FIND: begin
                    if (remaining > 0) begin
                        while (can_step(step, w.target)) begin
                            cursor    += step;
                            remaining -= step;
                            step <<= 1;
                        end
                        while (step > 0) begin
                            if (can_step(step, w.target)) begin
                                cursor    += step;
                                remaining -= step;
                            end
                            step >>= 1;
                        end
                        if (entries[cursor] < w.target) begin
                            cursor++;
                            remaining--;
                        end
                    end
                    expect_reply(remaining > 0);
                end
                default: ;
            endcase
        endfunction

        function void check_reply(t_out_word got);
            t_out_word exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word position=%h exhausted=%b",
                         $time, got.position, got.exhausted);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.position !== exp.position) begin
                $display("%0t: position expected %h actual %h",
                         $time, exp.position, got.position);
                errors++;
            end
            if (got.exhausted !== exp.exhausted) begin
                $display("%0t: exhausted expected %b actual %b",
                         $time, exp.exhausted, got.exhausted);
                errors++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_word          in_word   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_word         out_word;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DATA_W-1:0] cfg_data  = '0;

    bit                quiet_tail   = 1'b0;
    bit                hold_request = 1'b0;
    bit                gaps_on      = 1'b1;
    int unsigned       sent_items   = 0;
    bit [DATA_W-1:0]   sorted_top   = '0;
    cursor_checker     chk          = new();

    always #5 clk = ~clk;

    galloping_sorted_list_cursor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    task automatic send_word(input logic [2:0] action, input logic [DATA_W-1:0] target);
        t_in_word w;
        w.action = action;
        w.target = target;
        if (gaps_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        chk.note_command(w);
        if (action <= ACT_FIND) sent_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (chk.pending.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_marker(input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        chk.end_marker = value;
    endtask

    // target mostly near the cursor, at a distance of up to 2**max_exp entries
    function automatic logic [DATA_W-1:0] pick_target(input int max_exp);
        int unsigned       idx;
        logic [DATA_W-1:0] v;
        if (chk.loaded == 0 || $urandom_range(0, 9) == 0) return $urandom;
        idx = chk.cursor + $urandom_range(0, 1 << $urandom_range(0, max_exp));
        if (idx >= chk.loaded) idx = chk.loaded - 1;
        v = chk.entries[idx];
        case ($urandom_range(0, 3))
            0: v = v - 1;
            1: v = v + 1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic do_probe(input int max_exp);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12) send_word(ACT_FIND, pick_target(max_exp));
        else if (r < 17) send_word(ACT_NEXT, $urandom);
        else send_word(ACT_PEEK, $urandom);
    endtask

    task automatic append_sorted();
        sorted_top += ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1 << 16)
                                                  : $urandom_range(0, 12);
        send_word(ACT_APPEND, sorted_top);
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned goal;
        goal = sent_items + quota;
        while (sent_items < goal) begin
            gaps_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_word(ACT_REWIND, $urandom);
                    repeat ($urandom_range(3, 12)) do_probe(10);
                end
                4, 5, 6: begin
                    repeat ($urandom_range(1, 8)) begin
                        if ($urandom_range(0, 29) == 0) send_word(ACT_APPEND, $urandom);
                        else append_sorted();
                    end
                end
                7: begin
                    send_word(3'($urandom_range(0, ACT_LAST)), $urandom);
                end
                8: begin
                    repeat ($urandom_range(1, 4)) do_probe(10);
                end
                default: begin
                    send_word(3'($urandom_range(ACT_FIND + 1, ACT_LAST)), $urandom);
                end
            endcase
        end
    endtask

    initial begin : reply_sink
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned hold_left;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) chk.check_reply(out_word);
            if (hold_request) begin
                hold_request <= 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (quiet_tail) begin
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        calm_left = $urandom_range(20, 60);
                        out_stall <= 1'b0;
                    end
                    1, 2: begin
                        stall_left = $urandom_range(1, 3) - 1;
                        out_stall <= 1'b1;
                    end
                    default: out_stall <= 1'b0;
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] markers [5];
        markers[0] = '0;
        markers[1] = $urandom;
        markers[2] = '1;
        markers[3] = $urandom;
        markers[4] = 32'h8000_0000;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, then a short sorted list; reset end marker in force
        send_word(ACT_PEEK, '0);
        send_word(ACT_NEXT, '1);
        send_word(ACT_FIND, 32'h0000_1234);
        send_word(ACT_APPEND, '0);
        for (int k = 1; k <= 7; k++) send_word(ACT_APPEND, k * 10);
        send_word(ACT_PEEK, '0);
        send_word(ACT_REWIND, '0);
        send_word(ACT_APPEND, 80);
        send_word(ACT_PEEK, '0);
        send_word(ACT_NEXT, '0);
        send_word(ACT_FIND, '0);
        send_word(ACT_FIND, 35);
        send_word(ACT_FIND, 45);
        send_word(ACT_FIND, '1);
        send_word(ACT_NEXT, '0);
        send_word(ACT_REWIND, '0);
        send_word(ACT_FIND, 80);
        for (int a = ACT_FIND + 1; a <= ACT_LAST; a++) send_word(3'(a), $urandom);
        send_word(ACT_PEEK, '1);
        sorted_top = 100;
        drain();

        for (int p = 0; p < 5; p++) begin
            write_marker(markers[p]);
            if (p == 1) begin
                hold_request <= 1'b1;
                gaps_on = 1'b0;
                send_word(ACT_REWIND, '0);
                repeat (20) do_probe(10);
            end
            run_random(200);
            drain();
        end

        // last part: no idling, extend the list, then long finds
        quiet_tail <= 1'b1;
        write_marker($urandom);
        repeat (40) append_sorted();
        send_word(ACT_APPEND, '1);
        send_word(ACT_REWIND, '0);
        repeat (50) do_probe(16);
        send_word(ACT_FIND, '1);
        send_word(ACT_PEEK, '0);
        send_word(ACT_NEXT, '0);
        send_word(ACT_PEEK, '0);
        send_word(ACT_FIND, '0);
        send_word(ACT_REWIND, '0);
        send_word(ACT_FIND, '0);
        send_word(ACT_PEEK, '0);
        drain();
        repeat (64) @(posedge clk);

        if (chk.errors == 0 && chk.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(30_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/gsl_pkg.sv
rtl/gsl_ram.sv
rtl/gsl_engine.sv
rtl/gsl_outreg.sv
rtl/galloping_sorted_list_cursor.sv
verif/testbench.sv
